@@ hdl/sss_pkg.sv @@
`default_nettype none

package sss_pkg;

  // Field and register widths fixed by the block definition.
  localparam int unsigned SPEED_REQ_W  = 16;
  localparam int unsigned SPEED_MAG_W  = 10;
  localparam int unsigned SPEED_W      = SPEED_MAG_W + 1;
  localparam int unsigned CONST_W      = 24;
  localparam int unsigned PATTERN_W    = 4;
  localparam int unsigned PHASE_W      = 2;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = CONST_W;

  // Default width of the step period and wait counter.
  localparam int unsigned PERIOD_WIDTH_DEF = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SPEED     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_CONSTANT = 2'd2;

  // Register values after reset.
  localparam logic [SPEED_MAG_W-1:0] MAX_SPEED_RST     = 10'd375;
  localparam logic [SPEED_MAG_W-1:0] MIN_SPEED_RST     = 10'd60;
  localparam logic [CONST_W-1:0]     STEP_CONSTANT_RST = 24'd300000;

  // Input mode codes.
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } sss_state_t;

  // Status returned by the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Coil drive bits for each full-step phase.
  function automatic logic [PATTERN_W-1:0] coil_for(input logic [PHASE_W-1:0] ph);
    logic [PATTERN_W-1:0] pat;
    case (ph)
      2'd0: pat = 4'd5;
      2'd1: pat = 4'd6;
      2'd2: pat = 4'd10;
      2'd3: pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sss_if.sv @@
`default_nettype none

// Input channel: one tick or one speed command per transfer.
interface sss_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [sss_pkg::SPEED_REQ_W-1:0] speed_request;

  modport source (output valid, output mode, output speed_request, input ready);
  modport sink (input valid, input mode, input speed_request, output ready);
endinterface

// Result channel: one status item per input transfer.
interface sss_out_if;
  logic                                valid;
  logic                                ready;
  logic [sss_pkg::PATTERN_W-1:0]       coil_pattern;
  logic                                stepped;
  logic signed [sss_pkg::SPEED_W-1:0]  applied_speed;

  modport source (output valid, output coil_pattern, output stepped,
                  output applied_speed, input ready);
  modport sink (input valid, input coil_pattern, input stepped,
                input applied_speed, output ready);
endinterface

`default_nettype wire

@@ hdl/stepper_speed_step_sequencer_unit.sv @@
`default_nettype none

// Full-step sequencer for a two-phase stepper motor. Each input transfer is
// either a one-microsecond tick or a signed speed command in rpm, and each
// gives exactly one result transfer with the coil pattern of the last step,
// a step flag and the clamped speed in force. A tick's result is registered at
// the moment of acceptance. A command whose request differs from the speed in
// force and clamps to a nonzero value also returns its result at once, but
// starts the bit-serial divider that forms floor(step_time_constant / |speed|);
// the input stays closed after acceptance while the 24 quotient bits are
// produced one per cycle and the period is loaded. A new item is also held off
// while an earlier result waits at the output and the sink is not taking it.
// The user must write registers through the cfg port only while idle; the
// block does not enforce this. They take effect on the next speed command.
module stepper_speed_step_sequencer_unit #(
  parameter int unsigned PERIOD_WIDTH = sss_pkg::PERIOD_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  sss_in_if.sink                                in_ch,
  sss_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [sss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned QW = sss_pkg::CONST_W;
  localparam int unsigned MW = sss_pkg::SPEED_MAG_W;
  localparam int unsigned SW = sss_pkg::SPEED_W;
  localparam int unsigned RW = sss_pkg::SPEED_REQ_W;
  localparam int unsigned PW = PERIOD_WIDTH;

  // Configuration registers.
  logic [MW-1:0] max_speed_r;
  logic [MW-1:0] min_speed_r;
  logic [QW-1:0] step_const_r;

  // Sequencer state.
  sss_pkg::sss_state_t         state_r, state_nxt;
  logic signed [SW-1:0]        speed_r, speed_nxt;
  logic [sss_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [PW-1:0]               wait_r, wait_nxt;
  logic [PW-1:0]               period_r, period_nxt;
  logic [sss_pkg::PATTERN_W-1:0] pattern_r, pattern_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_stepped_r, out_stepped_nxt;
  logic [sss_pkg::PATTERN_W-1:0] out_pattern_r, out_pattern_nxt;
  logic signed [SW-1:0]          out_speed_r, out_speed_nxt;

  // Divider connection.
  logic                 div_start;
  sss_pkg::div_status_t div_status;
  logic [QW-1:0]        div_quot;
  logic [PW-1:0]        quot_sat;

  logic                 in_fire;
  logic                 out_fire;
  logic                 req_neg;
  logic [RW-1:0]        req_mag;
  logic [MW-1:0]        clamp_mag;
  logic signed [SW-1:0] clamp_speed;
  logic [PW-1:0]        wait_dec;

  sss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (step_const_r),
    .divisor  (clamp_mag),
    .status   (div_status),
    .quotient (div_quot)
  );

  // Fit the quotient into the period width, saturating if it overflows.
  generate
    if (PW > QW) begin : g_quot_wide
      assign quot_sat = {{(PW - QW){1'b0}}, div_quot};
    end else if (PW == QW) begin : g_quot_same
      assign quot_sat = div_quot;
    end else begin : g_quot_narrow
      assign quot_sat = (|div_quot[QW-1:PW]) ? {PW{1'b1}} : div_quot[PW-1:0];
    end
  endgenerate

  // Handshakes; the input stays closed while the divider runs.
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign in_ch.ready  = (state_r == sss_pkg::ST_IDLE) && !div_status.busy &&
                        (!out_valid_r || out_ch.ready);

  // Clamp the request on its magnitude and restore the sign.
  always_comb begin
    req_neg   = in_ch.speed_request[RW-1];
    req_mag   = req_neg ? (RW'(0) - in_ch.speed_request) : in_ch.speed_request;
    if (req_mag > {{(RW - MW){1'b0}}, max_speed_r}) begin
      clamp_mag = max_speed_r;
    end else if (req_mag < {{(RW - MW){1'b0}}, min_speed_r}) begin
      clamp_mag = '0;
    end else begin
      clamp_mag = req_mag[MW-1:0];
    end
    clamp_speed = req_neg ? (SW'(0) - {1'b0, clamp_mag}) : {1'b0, clamp_mag};
  end

  assign wait_dec  = (wait_r != '0) ? (wait_r - 1'b1) : wait_r;

  // Next state: ticks, commands and the divider result.
  always_comb begin
    state_nxt       = state_r;
    speed_nxt       = speed_r;
    phase_nxt       = phase_r;
    wait_nxt        = wait_r;
    period_nxt      = period_r;
    pattern_nxt     = pattern_r;
    out_valid_nxt   = out_valid_r && !out_fire;
    out_stepped_nxt = out_stepped_r;
    out_pattern_nxt = out_pattern_r;
    out_speed_nxt   = out_speed_r;
    div_start       = 1'b0;

    case (state_r)
      sss_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt   = 1'b1;
          out_stepped_nxt = 1'b0;
          if (in_ch.mode == sss_pkg::MODE_COMMAND) begin
            // The unclamped request is compared with the speed in force.
            if (in_ch.speed_request != {{(RW - SW){speed_r[SW-1]}}, speed_r}) begin
              speed_nxt = clamp_speed;
              if (clamp_mag == '0) begin
                period_nxt = '0;
              end else begin
                div_start = 1'b1;
                state_nxt = sss_pkg::ST_DIV;
              end
              out_speed_nxt = clamp_speed;
            end else begin
              out_speed_nxt = speed_r;
            end
            out_pattern_nxt = pattern_r;
          end else begin
            wait_nxt = wait_dec;
            if ((wait_dec == '0) && (speed_r != '0)) begin
              pattern_nxt     = sss_pkg::coil_for(phase_r);
              phase_nxt       = speed_r[SW-1] ? (phase_r - 1'b1) : (phase_r + 1'b1);
              wait_nxt        = period_r;
              out_stepped_nxt = 1'b1;
              out_pattern_nxt = sss_pkg::coil_for(phase_r);
            end else begin
              out_pattern_nxt = pattern_r;
            end
            out_speed_nxt = speed_r;
          end
        end
      end
      sss_pkg::ST_DIV: begin
        if (div_status.done) begin
          period_nxt = quot_sat;
          state_nxt  = sss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sss_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sss_pkg::ST_IDLE;
      speed_r     <= '0;
      phase_r     <= '0;
      wait_r      <= '0;
      period_r    <= '0;
      pattern_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      period_r    <= period_nxt;
      pattern_r   <= pattern_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_stepped_r <= out_stepped_nxt;
    out_pattern_r <= out_pattern_nxt;
    out_speed_r   <= out_speed_nxt;
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= sss_pkg::MAX_SPEED_RST;
      min_speed_r  <= sss_pkg::MIN_SPEED_RST;
      step_const_r <= sss_pkg::STEP_CONSTANT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_MAX_SPEED:     max_speed_r  <= cfg_data[MW-1:0];
        sss_pkg::CFG_MIN_SPEED:     min_speed_r  <= cfg_data[MW-1:0];
        sss_pkg::CFG_STEP_CONSTANT: step_const_r <= cfg_data[QW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.coil_pattern  = out_pattern_r;
  assign out_ch.stepped       = out_stepped_r;
  assign out_ch.applied_speed = out_speed_r;

endmodule

`default_nettype wire

@@ hdl/sss_div.sv @@
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module sss_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [sss_pkg::CONST_W-1:0]      dividend,
  input  wire logic [sss_pkg::SPEED_MAG_W-1:0]  divisor,
  output sss_pkg::div_status_t                  status,
  output logic [sss_pkg::CONST_W-1:0]           quotient
);

  localparam int unsigned QW  = sss_pkg::CONST_W;
  localparam int unsigned MW  = sss_pkg::SPEED_MAG_W;
  localparam int unsigned CNW = $clog2(QW + 1);

  logic [QW-1:0]  acc_r, acc_nxt;
  logic [MW-1:0]  rem_r, rem_nxt;
  logic [MW-1:0]  dvs_r, dvs_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;

  logic [MW:0]    trial;
  logic [MW:0]    diff;
  logic           fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, acc_r[QW-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Sequencing of the iterations.
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[QW-2:0], fits};
      rem_nxt = fits ? diff[MW-1:0] : trial[MW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign status   = {busy_r, done_r};
  assign quotient = acc_r;

endmodule

`default_nettype wire

@@ tb/stepper_speed_step_sequencer_unit_test.sv @@
`timescale 1ns / 100ps

module stepper_speed_step_sequencer_unit_test;
  import sss_pkg::*;

  localparam int unsigned PERIOD_W = PERIOD_WIDTH_DEF;
  localparam longint PERIOD_ALL_ONES = (longint'(1) << PERIOD_W) - 1;
  // Index 3 decodes to no register and must leave the settings alone.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  // Coil bits per phase, phase 0 in the low nibble.
  localparam logic [4*PATTERN_W-1:0] COIL_SEQUENCE = {4'd9, 4'd10, 4'd6, 4'd5};
  // Long enough to cover the period division after a command.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned COMMAND_PERCENT = 15;

  typedef struct packed {
    logic                   mode;
    logic [SPEED_REQ_W-1:0] request;
  } motion_item_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] coil;
    logic                 stepped;
    logic [SPEED_W-1:0]   speed;
  } step_status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sss_in_if in_ch ();
  sss_out_if out_ch ();

  stepper_speed_step_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register settings as the predictor sees them.
  logic [SPEED_MAG_W-1:0] lim_max;
  logic [SPEED_MAG_W-1:0] lim_min;
  logic [CONST_W-1:0] step_const;

  // Predicted sequencer state.
  logic signed [SPEED_W-1:0] run_speed;
  logic [PHASE_W-1:0] coil_phase;
  logic [PERIOD_W-1:0] wait_left;
  logic [PERIOD_W-1:0] step_gap;
  logic [PATTERN_W-1:0] held_pattern;

  motion_item_t queued_inputs[$];
  step_status_t status_due[$];
  int fault_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int last_request = 0;
  logic sender_gaps;
  logic sink_stalls;

  always #5 clk = ~clk;

  // Clamp a command or run one microsecond tick; returns the status it reports.
  function automatic step_status_t predict_status(input motion_item_t item);
    step_status_t st;
    int req;
    int hi;
    int lo;
    int sel;
    int mag;
    longint quot;
    req = int'($signed(item.request));
    hi = int'(lim_max);
    lo = int'(lim_min);
    st.stepped = 1'b0;
    if (item.mode == MODE_COMMAND) begin
      // A request equal to the speed in force keeps the old period.
      if (req != int'(run_speed)) begin
        if (req > hi) begin
          sel = hi;
        end else if (req < -hi) begin
          sel = -hi;
        end else if (req > -lo && req < lo) begin
          sel = 0;
        end else begin
          sel = req;
        end
        run_speed = sel[SPEED_W-1:0];
        mag = (sel < 0) ? -sel : sel;
        if (mag == 0) begin
          step_gap = '0;
        end else begin
          quot = longint'(step_const) / mag;
          if (quot > PERIOD_ALL_ONES) quot = PERIOD_ALL_ONES;
          step_gap = quot[PERIOD_W-1:0];
        end
      end
    end else begin
      // Count down first, then step if the wait has run out.
      if (wait_left != '0) wait_left = wait_left - 1'b1;
      if (wait_left == '0 && run_speed != '0) begin
        held_pattern = COIL_SEQUENCE[coil_phase*PATTERN_W +: PATTERN_W];
        coil_phase = (run_speed > 0) ? coil_phase + 1'b1 : coil_phase - 1'b1;
        wait_left = step_gap;
        st.stepped = 1'b1;
      end
    end
    st.coil = held_pattern;
    st.speed = run_speed;
    return st;
  endfunction

  task automatic add_tick();
    motion_item_t item;
    item.mode = MODE_TICK;
    item.request = 16'($urandom);
    queued_inputs.push_back(item);
  endtask

  task automatic add_command(input int req);
    motion_item_t item;
    item.mode = MODE_COMMAND;
    item.request = req[SPEED_REQ_W-1:0];
    last_request = req;
    queued_inputs.push_back(item);
  endtask

  // Mostly ticks; commands aim at the clamp edges, zero and repeats, or are random.
  task automatic add_random_item();
    int sgn;
    if ($urandom_range(0, 99) >= COMMAND_PERCENT) begin
      add_tick();
    end else begin
      sgn = ($urandom_range(0, 1) != 0) ? -1 : 1;
      case ($urandom_range(0, 5))
        0: add_command($urandom);
        1: add_command(sgn * (int'(lim_max) + int'($urandom_range(0, 4)) - 2));
        2: add_command(sgn * (int'(lim_min) + int'($urandom_range(0, 4)) - 2));
        3: add_command(0);
        4: add_command(last_request);
        default: add_command(sgn * int'($urandom_range(0, 1100)));
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_SPEED: lim_max = val[SPEED_MAG_W-1:0];
      CFG_MIN_SPEED: lim_min = val[SPEED_MAG_W-1:0];
      CFG_STEP_CONSTANT: step_const = val[CONST_W-1:0];
      default: ;
    endcase
  endtask

  // Hold off until every item has gone in and every status has come back.
  task automatic settle_block();
    do @(posedge clk);
    while (queued_inputs.size() != 0 || in_ch.valid || status_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input side: predict on each transfer, then present the next item.
  always @(posedge clk) begin
    motion_item_t taken;
    motion_item_t nxt;
    logic send;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.mode = in_ch.mode;
        taken.request = in_ch.speed_request;
        status_due.push_back(predict_status(taken));
      end
      if (!in_ch.valid || in_ch.ready) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_inputs.size() != 0) begin
          nxt = queued_inputs.pop_front();
          send = 1'b1;
          if (sender_gaps && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
        end
        in_ch.valid <= send;
        if (send) begin
          in_ch.mode <= nxt.mode;
          in_ch.speed_request <= nxt.request;
        end
      end
    end
  end

  // Result side: check each transfer against the oldest prediction.
  always @(posedge clk) begin
    step_status_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_due.size() == 0) begin
          $error("status transfer with no item outstanding");
          fault_count++;
        end else begin
          want = status_due.pop_front();
          if (out_ch.coil_pattern !== want.coil) begin
            $error("coil_pattern: expected %0d, got %0d", want.coil, out_ch.coil_pattern);
            fault_count++;
          end
          if (out_ch.stepped !== want.stepped) begin
            $error("stepped: expected %0d, got %0d", want.stepped, out_ch.stepped);
            fault_count++;
          end
          if (out_ch.applied_speed !== want.speed) begin
            $error("applied_speed: expected %0d, got %0d",
                   $signed(want.speed), out_ch.applied_speed);
            fault_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Run sequence: reset, directed phases, random phases, drain.
  initial begin
    int max_v;
    int min_v;
    int const_v;
    int idle_pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_SPEED;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.speed_request = '0;
    out_ch.ready = 1'b0;
    lim_max = MAX_SPEED_RST;
    lim_min = MIN_SPEED_RST;
    step_const = STEP_CONSTANT_RST;
    run_speed = '0;
    coil_phase = '0;
    wait_left = '0;
    step_gap = '0;
    held_pattern = '0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: clamping at both signs, ignored repeats, stop.
    add_tick();
    add_command(0);
    add_command(-32768);
    add_command(-375);
    add_command(-376);
    add_command(-59);
    add_command(32767);
    add_command(375);
    add_command(60);
    add_command(-60);
    add_command(59);
    add_tick();
    settle_block();

    // Widest range and a tiny constant: zero period, a step on every tick.
    write_reg(CFG_MAX_SPEED, 1023);
    write_reg(CFG_MIN_SPEED, 1);
    write_reg(CFG_STEP_CONSTANT, 1);
    write_reg(CFG_SPARE, $urandom);
    add_command(1023);
    repeat (3) add_tick();
    add_command(-1024);
    repeat (3) add_tick();
    add_command(0);
    add_tick();
    settle_block();

    // Minimum above maximum and the largest constant; motor left stopped.
    write_reg(CFG_MAX_SPEED, 1);
    write_reg(CFG_MIN_SPEED, 1023);
    write_reg(CFG_STEP_CONSTANT, 'hFFFFFF);
    add_command(2);
    add_command(-2);
    add_command(1);
    add_command(1023);
    add_command(0);
    settle_block();

    // Random settings, random idling, the last phase without idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      max_v = $urandom_range(1, 1023);
      min_v = ($urandom_range(0, 3) != 0) ? $urandom_range(1, max_v) : $urandom_range(1, 1023);
      case ($urandom_range(0, 19))
        0, 1, 2: const_v = $urandom_range(300, 3000);
        3, 4, 5, 6, 7: const_v = $urandom_range(1, 50);
        default: const_v = $urandom_range(1, 300);
      endcase
      write_reg(CFG_MAX_SPEED, max_v);
      write_reg(CFG_MIN_SPEED, min_v);
      write_reg(CFG_STEP_CONSTANT, const_v);
      idle_pick = $urandom_range(0, 3);
      sender_gaps = (ph != RANDOM_PHASES - 1) && idle_pick[0];
      sink_stalls = (ph != RANDOM_PHASES - 1) && idle_pick[1];
      repeat (ITEMS_PER_PHASE) add_random_item();
      settle_block();
    end

    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
